[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl, sampled on clock and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clock
`define ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// property checked in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/core/cosp_pkg.sv]
// constants and codes for the coap option stream parser
package cosp_pkg;

   // message format
   localparam int unsigned MAX_TOKEN        = 8;
   localparam int unsigned HEADER_BYTES     = 4;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1152;

   // nibble codes for extended delta and length
   localparam logic [3:0] NIB_EXT8     = 4'd13;
   localparam logic [3:0] NIB_EXT16    = 4'd14;
   localparam logic [3:0] NIB_RESERVED = 4'd15;
   localparam logic [7:0] EXT8_BIAS    = 8'd13;
   localparam logic [15:0] EXT16_BIAS  = 16'd269;
   localparam logic [7:0] MARKER_BYTE  = 8'hFF;
   localparam logic [1:0] HDR_VERSION  = 2'b01;

   // parse phases
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_TOKEN    = 3'd1;
   localparam logic [2:0] PH_OPTHEAD  = 3'd2;
   localparam logic [2:0] PH_EXTDELTA = 3'd3;
   localparam logic [2:0] PH_EXTLEN   = 3'd4;
   localparam logic [2:0] PH_VALUE    = 3'd5;
   localparam logic [2:0] PH_PAYLOAD  = 3'd6;

   // byte kinds
   localparam logic [3:0] KIND_HEADER   = 4'd0;
   localparam logic [3:0] KIND_TOKEN    = 4'd1;
   localparam logic [3:0] KIND_OPTHEAD  = 4'd2;
   localparam logic [3:0] KIND_EXTDELTA = 4'd3;
   localparam logic [3:0] KIND_EXTLEN   = 4'd4;
   localparam logic [3:0] KIND_VALUE    = 4'd5;
   localparam logic [3:0] KIND_MARKER   = 4'd6;
   localparam logic [3:0] KIND_PAYLOAD  = 4'd7;
   localparam logic [3:0] KIND_IGNORED  = 4'd8;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SHORT     = 3'd1;
   localparam logic [2:0] ERR_VERSION   = 3'd2;
   localparam logic [2:0] ERR_TOKEN     = 3'd3;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
   localparam logic [2:0] ERR_MALFORMED = 3'd5;

   // register map
   localparam logic REG_MAX_LENGTH = 1'b0;

endpackage

[rtl/core/coap_option_stream_parser.sv]
// CoAP option stream parser: one result per message byte, at one byte per cycle unless stalled
//
// Each request carries one message byte and a last flag; each produces exactly one
// response the next cycle, tagging the byte (header, token, option head, extended
// delta or length, value, marker, payload, ignored) with the running option number,
// the decoded option length, an option-done flag, the first error of the message
// and the end flag. A request is taken every cycle while the response side is not
// stalled; the figure is set by the update of the parse state from each byte, which
// the next byte needs. The response register holds a stalled result while the next
// request waits on the input. max_length (byte address 0) caps the message length.
module coap_option_stream_parser
   import cosp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_option_number,
   output logic [16:0] rsp_option_length,
   output logic        rsp_option_done,
   output logic [2:0]  rsp_error,
   output logic        rsp_message_end,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "assert_macros.svh"

   logic        req_fire;
   logic        cfg_write;

   logic [15:0] max_length_ff;

   // parse state
   logic [2:0]  phase_ff,         phase_in;
   logic [15:0] byte_count_ff,    byte_count_in;
   logic [3:0]  token_left_ff,    token_left_in;
   logic [15:0] number_acc_ff,    number_acc_in;
   logic [3:0]  delta_code_ff,    delta_code_in;
   logic [3:0]  length_code_ff,   length_code_in;
   logic [7:0]  ext_byte_high_ff, ext_byte_high_in;
   logic [1:0]  ext_left_ff,      ext_left_in;
   logic [16:0] value_left_ff,    value_left_in;
   logic [2:0]  error_flag_ff,    error_flag_in;
   logic [16:0] opt_len_ff,       opt_len_in;

   // response register
   logic        rsp_valid_ff,     rsp_valid_in;
   logic [3:0]  rsp_kind_ff,      rsp_kind_in;
   logic [15:0] rsp_number_ff;
   logic [16:0] rsp_length_ff,    rsp_length_in;
   logic        rsp_done_ff,      rsp_done_in;
   logic [2:0]  rsp_error_ff,     rsp_error_in;
   logic        rsp_end_ff;

   // handshakes
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid_in = req_fire | (rsp_valid_ff & rsp_stall);

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == REG_MAX_LENGTH) ? {16'd0, max_length_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (cfg_write && paddr[2] == REG_MAX_LENGTH) begin
         max_length_ff <= pwdata[15:0];
      end
   end

   // per-byte parse step
   always_comb begin
      logic [16:0] pos;
      logic [3:0]  tok_sel;
      logic [3:0]  tok_dec;
      logic [16:0] val_dec;
      logic [15:0] ext_delta;
      logic [16:0] ext_len;
      logic        run_after_delta;
      logic [3:0]  ad_length_code;
      logic [3:0]  kind;
      logic        done;
      logic [2:0]  err;

      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      token_left_in    = token_left_ff;
      number_acc_in    = number_acc_ff;
      delta_code_in    = delta_code_ff;
      length_code_in   = length_code_ff;
      ext_byte_high_in = ext_byte_high_ff;
      ext_left_in      = ext_left_ff;
      value_left_in    = value_left_ff;
      opt_len_in       = opt_len_ff;

      pos             = {1'b0, byte_count_ff} + 17'd1;
      tok_sel         = (pos == 17'd1) ? req_data_byte[3:0] : token_left_ff;
      tok_dec         = token_left_ff - 4'd1;
      val_dec         = value_left_ff - 17'd1;
      ext_delta       = (delta_code_ff == NIB_EXT8)
                        ? ({8'd0, req_data_byte} + {8'd0, EXT8_BIAS})
                        : ({ext_byte_high_ff, req_data_byte} + EXT16_BIAS);
      ext_len         = (length_code_ff == NIB_EXT8)
                        ? ({9'd0, req_data_byte} + {9'd0, EXT8_BIAS})
                        : ({1'b0, ext_byte_high_ff, req_data_byte} + {1'b0, EXT16_BIAS});
      run_after_delta = 1'b0;
      ad_length_code  = length_code_ff;
      kind            = KIND_IGNORED;
      done            = 1'b0;
      err             = ERR_NONE;

      priority if (error_flag_ff != ERR_NONE) begin
         err = error_flag_ff;
      end else if (req_last && pos <= 17'(HEADER_BYTES)) begin
         err = ERR_SHORT;
      end else if (pos > {1'b0, max_length_ff}) begin
         err = ERR_TOO_LARGE;
      end else begin
         byte_count_in = pos[15:0];
         unique case (phase_ff)
            PH_HEADER: begin
               priority if (pos == 17'd1 && req_data_byte[7:6] != HDR_VERSION) begin
                  err = ERR_VERSION;
               end else if (pos == 17'd1 && req_data_byte[3:0] > 4'(MAX_TOKEN)) begin
                  err = ERR_TOKEN;
               end else begin
                  token_left_in = tok_sel;
                  kind = KIND_HEADER;
                  if (pos >= 17'(HEADER_BYTES)) begin
                     phase_in = (tok_sel != 4'd0) ? PH_TOKEN : PH_OPTHEAD;
                  end
               end
            end
            PH_TOKEN: begin
               kind = KIND_TOKEN;
               token_left_in = tok_dec;
               if (tok_dec == 4'd0) begin
                  phase_in = PH_OPTHEAD;
               end
            end
            PH_OPTHEAD: begin
               if (req_data_byte == MARKER_BYTE) begin
                  kind = KIND_MARKER;
                  phase_in = PH_PAYLOAD;
               end else begin
                  delta_code_in  = req_data_byte[7:4];
                  length_code_in = req_data_byte[3:0];
                  if (req_data_byte[7:4] == NIB_RESERVED ||
                      req_data_byte[3:0] == NIB_RESERVED) begin
                     err = ERR_MALFORMED;
                  end else begin
                     kind = KIND_OPTHEAD;
                     opt_len_in = (req_data_byte[3:0] < NIB_EXT8)
                                  ? {13'd0, req_data_byte[3:0]} : 17'd0;
                     if (req_data_byte[7:4] >= NIB_EXT8) begin
                        phase_in    = PH_EXTDELTA;
                        ext_left_in = (req_data_byte[7:4] == NIB_EXT8) ? 2'd1 : 2'd2;
                     end else begin
                        number_acc_in   = number_acc_ff + {12'd0, req_data_byte[7:4]};
                        run_after_delta = 1'b1;
                        ad_length_code  = req_data_byte[3:0];
                     end
                  end
               end
            end
            PH_EXTDELTA: begin
               kind = KIND_EXTDELTA;
               if (ext_left_ff == 2'd2) begin
                  ext_byte_high_in = req_data_byte;
                  ext_left_in      = 2'd1;
               end else begin
                  number_acc_in   = number_acc_ff + ext_delta;
                  ext_left_in     = 2'd0;
                  run_after_delta = 1'b1;
               end
            end
            PH_EXTLEN: begin
               kind = KIND_EXTLEN;
               if (ext_left_ff == 2'd2) begin
                  ext_byte_high_in = req_data_byte;
                  ext_left_in      = 2'd1;
               end else begin
                  opt_len_in    = ext_len;
                  ext_left_in   = 2'd0;
                  phase_in      = PH_VALUE;
                  value_left_in = ext_len;
               end
            end
            PH_VALUE: begin
               kind = KIND_VALUE;
               value_left_in = val_dec;
               if (val_dec == 17'd0) begin
                  phase_in = PH_OPTHEAD;
                  done     = 1'b1;
               end
            end
            default: begin
               kind = KIND_PAYLOAD;
            end
         endcase

         // move on once the option delta is known
         if (run_after_delta) begin
            priority if (ad_length_code >= NIB_EXT8) begin
               phase_in    = PH_EXTLEN;
               ext_left_in = (ad_length_code == NIB_EXT8) ? 2'd1 : 2'd2;
            end else if (ad_length_code != 4'd0) begin
               phase_in      = PH_VALUE;
               value_left_in = {13'd0, ad_length_code};
            end else begin
               phase_in = PH_OPTHEAD;
               done     = 1'b1;
            end
         end

         // message cut off inside a token, extended field or value
         if (err == ERR_NONE && req_last &&
             (phase_in == PH_TOKEN || phase_in == PH_EXTDELTA ||
              phase_in == PH_EXTLEN || phase_in == PH_VALUE)) begin
            err = ERR_MALFORMED;
         end
      end

      error_flag_in = (err != ERR_NONE) ? err : error_flag_ff;

      // response fields
      rsp_error_in  = err;
      rsp_length_in = 17'd0;
      if (err != ERR_NONE) begin
         rsp_kind_in = KIND_IGNORED;
         rsp_done_in = 1'b0;
      end else begin
         rsp_kind_in = kind;
         rsp_done_in = done;
         if (kind >= KIND_OPTHEAD && kind <= KIND_VALUE) begin
            rsp_length_in = opt_len_in;
         end
      end
   end

   // parse state registers, cleared after the last byte of a message
   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_last)) begin
         phase_ff         <= PH_HEADER;
         byte_count_ff    <= 16'd0;
         token_left_ff    <= 4'd0;
         number_acc_ff    <= 16'd0;
         delta_code_ff    <= 4'd0;
         length_code_ff   <= 4'd0;
         ext_byte_high_ff <= 8'd0;
         ext_left_ff      <= 2'd0;
         value_left_ff    <= 17'd0;
         error_flag_ff    <= ERR_NONE;
         opt_len_ff       <= 17'd0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         token_left_ff    <= token_left_in;
         number_acc_ff    <= number_acc_in;
         delta_code_ff    <= delta_code_in;
         length_code_ff   <= length_code_in;
         ext_byte_high_ff <= ext_byte_high_in;
         ext_left_ff      <= ext_left_in;
         value_left_ff    <= value_left_in;
         error_flag_ff    <= error_flag_in;
         opt_len_ff       <= opt_len_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_number_ff <= number_acc_in;
         rsp_length_ff <= rsp_length_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_error_ff  <= rsp_error_in;
         rsp_end_ff    <= req_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_option_number = rsp_number_ff;
   assign rsp_option_length = rsp_length_ff;
   assign rsp_option_done   = rsp_done_ff;
   assign rsp_error         = rsp_error_ff;
   assign rsp_message_end   = rsp_end_ff;

   // checks
   `ASSERT_NEXT(a_clear_after_last, req_fire && req_last,
      byte_count_ff == 16'd0 && phase_ff == PH_HEADER && error_flag_ff == ERR_NONE,
      "parse state not cleared after last byte")
   `ASSERT_NEXT(a_error_sticky, req_fire && !req_last && error_flag_ff != ERR_NONE,
      error_flag_ff == $past(error_flag_ff) && rsp_error_ff == error_flag_ff,
      "flagged error changed inside a message")
   `ASSERT_IMPLY(a_error_ignored, rsp_valid_ff && rsp_error_ff != ERR_NONE,
      rsp_kind_ff == KIND_IGNORED && !rsp_done_ff && rsp_length_ff == 17'd0,
      "errored byte not reported as ignored")
   `ASSERT_IMPLY(a_done_kind, rsp_valid_ff && rsp_done_ff,
      rsp_kind_ff == KIND_OPTHEAD || rsp_kind_ff == KIND_EXTDELTA ||
      rsp_kind_ff == KIND_EXTLEN || rsp_kind_ff == KIND_VALUE,
      "option done on a byte outside an option")

endmodule
